[src/tcts_pkg.sv]
`default_nettype none
package tcts_pkg;

    localparam int unsigned BLOCK_BYTES = 512;

    localparam int unsigned LEN_W   = 10;
    localparam int unsigned BLOCK_W = 16;
    localparam int unsigned TIMER_W = 24;
    localparam int unsigned TICKS_W = 16;
    localparam int unsigned RETRY_W = 3;
    localparam int unsigned HDR_BYTES = 4;

    localparam logic [LEN_W-1:0] BLOCK_LEN = LEN_W'(BLOCK_BYTES);
    localparam logic [LEN_W-1:0] HDR_LEN   = LEN_W'(HDR_BYTES);
    localparam logic [LEN_W-1:0] MAX_PKT   = LEN_W'(BLOCK_BYTES + HDR_BYTES);

    localparam logic [RETRY_W-1:0] RETRY_MAX = 3'd7;

    // configuration register indexes
    localparam logic CFG_TIMEOUT_TICKS = 1'b0;
    localparam logic CFG_RETRY_LIMIT   = 1'b1;

    localparam logic [TICKS_W-1:0] TIMEOUT_RESET = 16'd20000;
    localparam logic [RETRY_W-1:0] RETRY_RESET   = 3'd3;

    // actions
    localparam logic [1:0] ACT_START_READ  = 2'd0;
    localparam logic [1:0] ACT_START_WRITE = 2'd1;
    localparam logic [1:0] ACT_PACKET      = 2'd2;
    localparam logic [1:0] ACT_TICK        = 2'd3;

    // received opcodes
    localparam logic [15:0] OPC_DATA  = 16'd3;
    localparam logic [15:0] OPC_ACK   = 16'd4;
    localparam logic [15:0] OPC_ERROR = 16'd5;

    // send kinds
    localparam logic [2:0] KIND_NONE  = 3'd0;
    localparam logic [2:0] KIND_RRQ   = 3'd1;
    localparam logic [2:0] KIND_WRQ   = 3'd2;
    localparam logic [2:0] KIND_ACK   = 3'd3;
    localparam logic [2:0] KIND_DATA  = 3'd4;
    localparam logic [2:0] KIND_RETX  = 3'd5;
    localparam logic [2:0] KIND_ERROR = 3'd6;

    // status codes
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_WRONG_SIZE = 3'd1;
    localparam logic [2:0] ST_UNEXPECTED = 3'd2;
    localparam logic [2:0] ST_STORE_ERR  = 3'd3;
    localparam logic [2:0] ST_RETRY_TMO  = 3'd4;
    localparam logic [2:0] ST_PEER_ERR   = 3'd5;

    typedef enum logic [2:0] {
        MODE_IDLE  = 3'b001,
        MODE_READ  = 3'b010,
        MODE_WRITE = 3'b100
    } mode_t;

    typedef struct packed {
        logic [2:0]         send_kind;
        logic [BLOCK_W-1:0] send_block;
        logic [LEN_W-1:0]   send_length;
        logic               store_payload;
        logic [LEN_W-1:0]   payload_length;
        logic [2:0]         status;
        logic               session_done;
        logic               last_result;
    } result_t;

    // results produced by one request: count is 0, 1 or 2
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } result_push_t;

    function automatic result_t mk_result(
        input logic [2:0]         kind,
        input logic [BLOCK_W-1:0] blk,
        input logic [LEN_W-1:0]   slen,
        input logic               store,
        input logic [LEN_W-1:0]   plen,
        input logic [2:0]         status,
        input logic               done,
        input logic               last
    );
        result_t r;
        r.send_kind      = kind;
        r.send_block     = blk;
        r.send_length    = slen;
        r.store_payload  = store;
        r.payload_length = plen;
        r.status         = status;
        r.session_done   = done;
        r.last_result    = last;
        return r;
    endfunction

endpackage
`default_nettype wire

[src/tftp_client_transfer_sequencer_core.sv]
// Client-side TFTP transfer sequencer. Each request (start read, start write,
// received packet header, or timer tick) is captured in an input register and
// resolved against the session state once the result queue has room; the
// results it produces (at most two) go into a four-entry result queue. A new
// request is taken every clock cycle while the input register is empty or the
// queue has room for two more results, so requests can arrive back to back; the
// input stalls only when results back up because the output side stalls or
// drains one result per cycle behind requests that produce two. A result
// passes through the input register and then the result queue, whose head
// drives the output directly. The user must write the configuration registers
// (timeout_ticks at index 0, retry_limit at index 1) only while no request is
// in flight; the block itself does not enforce this.
`default_nettype none
module tftp_client_transfer_sequencer_core (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          write_enable,
    input  wire logic                          write_index,
    input  wire logic [tcts_pkg::TICKS_W-1:0]  write_data,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [1:0]                    action,
    input  wire logic [tcts_pkg::LEN_W-1:0]    packet_length,
    input  wire logic [15:0]                   packet_opcode,
    input  wire logic [tcts_pkg::BLOCK_W-1:0]  packet_block,
    input  wire logic [tcts_pkg::LEN_W-1:0]    next_chunk_length,
    input  wire logic                          store_succeeded,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [2:0]                         send_kind,
    output logic [tcts_pkg::BLOCK_W-1:0]       send_block,
    output logic [tcts_pkg::LEN_W-1:0]         send_length,
    output logic                               store_payload,
    output logic [tcts_pkg::LEN_W-1:0]         payload_length,
    output logic [2:0]                         status,
    output logic                               session_done,
    output logic                               last_result
);

    tcts_pkg::result_push_t push;
    tcts_pkg::result_t      head;
    logic                   fifo_room;

    tcts_engine u_engine (
        .clk               (clk),
        .rst_n             (rst_n),
        .write_enable      (write_enable),
        .write_index       (write_index),
        .write_data        (write_data),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .action            (action),
        .packet_length     (packet_length),
        .packet_opcode     (packet_opcode),
        .packet_block      (packet_block),
        .next_chunk_length (next_chunk_length),
        .store_succeeded   (store_succeeded),
        .fifo_room         (fifo_room),
        .push              (push)
    );

    tcts_result_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (fifo_room),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .head      (head)
    );

    assign send_kind      = head.send_kind;
    assign send_block     = head.send_block;
    assign send_length    = head.send_length;
    assign store_payload  = head.store_payload;
    assign payload_length = head.payload_length;
    assign status         = head.status;
    assign session_done   = head.session_done;
    assign last_result    = head.last_result;

endmodule
`default_nettype wire

[src/tcts_engine.sv]
`default_nettype none
module tcts_engine (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             write_enable,
    input  wire logic                             write_index,
    input  wire logic [tcts_pkg::TICKS_W-1:0]     write_data,
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire logic [1:0]                       action,
    input  wire logic [tcts_pkg::LEN_W-1:0]       packet_length,
    input  wire logic [15:0]                      packet_opcode,
    input  wire logic [tcts_pkg::BLOCK_W-1:0]     packet_block,
    input  wire logic [tcts_pkg::LEN_W-1:0]       next_chunk_length,
    input  wire logic                             store_succeeded,
    input  wire logic                             fifo_room,
    output tcts_pkg::result_push_t                push
);

    logic [tcts_pkg::TICKS_W-1:0]  timeout_reg;
    logic [tcts_pkg::RETRY_W-1:0]  retry_limit_reg;

    logic                          in_valid_reg;
    logic [1:0]                    action_reg;
    logic [tcts_pkg::LEN_W-1:0]    plen_reg;
    logic [15:0]                   opcode_reg;
    logic [tcts_pkg::BLOCK_W-1:0]  pblk_reg;
    logic [tcts_pkg::LEN_W-1:0]    chunk_reg;
    logic                          stored_reg;

    tcts_pkg::mode_t               mode_reg, mode_next;
    logic [tcts_pkg::BLOCK_W-1:0]  block_reg, block_next;
    logic                          final_reg, final_next;
    logic [tcts_pkg::RETRY_W-1:0]  retry_reg, retry_next;
    logic [tcts_pkg::TIMER_W-1:0]  timer_reg, timer_next;

    logic                          fire;
    logic                          load;
    logic [tcts_pkg::TICKS_W-1:0]  base;
    logic [tcts_pkg::TIMER_W-1:0]  timer_dec;
    logic [tcts_pkg::RETRY_W-1:0]  retry_inc;
    logic [tcts_pkg::LEN_W-1:0]    pay;
    logic [tcts_pkg::LEN_W-1:0]    chunk;
    logic [tcts_pkg::BLOCK_W-1:0]  blk_inc;
    logic                          bad_size;

    assign fire     = in_valid_reg && fifo_room;
    assign in_stall = in_valid_reg && !fifo_room;
    assign load     = in_valid && !in_stall;

    assign base      = (timeout_reg == '0) ? tcts_pkg::TICKS_W'(1) : timeout_reg;
    assign timer_dec = timer_reg - tcts_pkg::TIMER_W'(1);
    assign retry_inc = retry_reg + tcts_pkg::RETRY_W'(1);
    assign pay       = plen_reg - tcts_pkg::HDR_LEN;
    assign chunk     = (chunk_reg > tcts_pkg::BLOCK_LEN) ? tcts_pkg::BLOCK_LEN : chunk_reg;
    assign blk_inc   = block_reg + tcts_pkg::BLOCK_W'(1);
    assign bad_size  = (plen_reg < tcts_pkg::HDR_LEN) || (plen_reg > tcts_pkg::MAX_PKT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg     <= tcts_pkg::TIMEOUT_RESET;
            retry_limit_reg <= tcts_pkg::RETRY_RESET;
        end
        else if (write_enable)
        begin
            unique case (write_index)
                tcts_pkg::CFG_TIMEOUT_TICKS: timeout_reg <= write_data;
                tcts_pkg::CFG_RETRY_LIMIT:
                    retry_limit_reg <= write_data[tcts_pkg::RETRY_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (load)
            in_valid_reg <= 1'b1;
        else if (fire)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            action_reg <= action;
            plen_reg   <= packet_length;
            opcode_reg <= packet_opcode;
            pblk_reg   <= packet_block;
            chunk_reg  <= next_chunk_length;
            stored_reg <= store_succeeded;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= tcts_pkg::MODE_IDLE;
            block_reg <= '0;
            final_reg <= 1'b0;
            retry_reg <= '0;
            timer_reg <= '0;
        end
        else if (fire)
        begin
            mode_reg  <= mode_next;
            block_reg <= block_next;
            final_reg <= final_next;
            retry_reg <= retry_next;
            timer_reg <= timer_next;
        end
    end

    always_comb
    begin
        mode_next   = mode_reg;
        block_next  = block_reg;
        final_next  = final_reg;
        retry_next  = retry_reg;
        timer_next  = timer_reg;
        push.count  = 2'd0;
        push.first  = '0;
        push.second = '0;

        unique case (action_reg)
            tcts_pkg::ACT_START_READ, tcts_pkg::ACT_START_WRITE:
            begin
                if (mode_reg == tcts_pkg::MODE_IDLE)
                begin
                    mode_next  = (action_reg == tcts_pkg::ACT_START_READ) ?
                                 tcts_pkg::MODE_READ : tcts_pkg::MODE_WRITE;
                    block_next = '0;
                    final_next = 1'b0;
                    retry_next = '0;
                    timer_next = tcts_pkg::TIMER_W'(base);
                    push.count = 2'd1;
                    push.first = tcts_pkg::mk_result(
                        (action_reg == tcts_pkg::ACT_START_READ) ?
                            tcts_pkg::KIND_RRQ : tcts_pkg::KIND_WRQ,
                        '0, '0, 1'b0, '0, tcts_pkg::ST_OK, 1'b0, 1'b1);
                end
            end
            tcts_pkg::ACT_TICK:
            begin
                if (mode_reg != tcts_pkg::MODE_IDLE && timer_reg != '0)
                begin
                    timer_next = timer_dec;
                    if (timer_dec == '0)
                    begin
                        if (retry_reg > retry_limit_reg || retry_reg == tcts_pkg::RETRY_MAX)
                        begin
                            // retries exhausted: retransmit, then abort
                            push.count  = 2'd2;
                            push.first  = tcts_pkg::mk_result(tcts_pkg::KIND_RETX,
                                block_reg, '0, 1'b0, '0, tcts_pkg::ST_OK, 1'b0, 1'b0);
                            push.second = tcts_pkg::mk_result(tcts_pkg::KIND_ERROR,
                                '0, '0, 1'b0, '0, tcts_pkg::ST_RETRY_TMO, 1'b1, 1'b1);
                            mode_next   = tcts_pkg::MODE_IDLE;
                            timer_next  = '0;
                            retry_next  = '0;
                        end
                        else
                        begin
                            // back off: reload with base doubled per retry
                            retry_next = retry_inc;
                            timer_next = tcts_pkg::TIMER_W'(base) << retry_inc;
                            push.count = 2'd1;
                            push.first = tcts_pkg::mk_result(tcts_pkg::KIND_RETX,
                                block_reg, '0, 1'b0, '0, tcts_pkg::ST_OK, 1'b0, 1'b1);
                        end
                    end
                end
            end
            tcts_pkg::ACT_PACKET:
            begin
                if (mode_reg != tcts_pkg::MODE_IDLE)
                begin
                    if (bad_size)
                    begin
                        push.count = 2'd1;
                        push.first = tcts_pkg::mk_result(tcts_pkg::KIND_ERROR,
                            '0, '0, 1'b0, '0, tcts_pkg::ST_WRONG_SIZE, 1'b1, 1'b1);
                        mode_next  = tcts_pkg::MODE_IDLE;
                        timer_next = '0;
                        retry_next = '0;
                    end
                    else if (opcode_reg == tcts_pkg::OPC_ERROR)
                    begin
                        push.count = 2'd1;
                        push.first = tcts_pkg::mk_result(tcts_pkg::KIND_NONE,
                            '0, '0, 1'b0, '0, tcts_pkg::ST_PEER_ERR, 1'b0, 1'b1);
                    end
                    else if (mode_reg == tcts_pkg::MODE_READ)
                    begin
                        if (opcode_reg != tcts_pkg::OPC_DATA)
                        begin
                            push.count = 2'd1;
                            push.first = tcts_pkg::mk_result(tcts_pkg::KIND_ERROR,
                                '0, '0, 1'b0, '0, tcts_pkg::ST_UNEXPECTED, 1'b1, 1'b1);
                            mode_next  = tcts_pkg::MODE_IDLE;
                            timer_next = '0;
                            retry_next = '0;
                        end
                        else if (pblk_reg == blk_inc)
                        begin
                            if (pay != '0 && !stored_reg)
                            begin
                                push.count = 2'd1;
                                push.first = tcts_pkg::mk_result(tcts_pkg::KIND_ERROR,
                                    '0, '0, 1'b0, '0, tcts_pkg::ST_STORE_ERR, 1'b1, 1'b1);
                                mode_next  = tcts_pkg::MODE_IDLE;
                                timer_next = '0;
                                retry_next = '0;
                            end
                            else
                            begin
                                block_next = pblk_reg;
                                retry_next = '0;
                                timer_next = tcts_pkg::TIMER_W'(base);
                                push.count = 2'd1;
                                push.first = tcts_pkg::mk_result(tcts_pkg::KIND_ACK,
                                    pblk_reg, '0, pay != '0, pay, tcts_pkg::ST_OK,
                                    pay < tcts_pkg::BLOCK_LEN, 1'b1);
                                // short block ends the read
                                if (pay < tcts_pkg::BLOCK_LEN)
                                begin
                                    mode_next  = tcts_pkg::MODE_IDLE;
                                    timer_next = '0;
                                end
                            end
                        end
                    end
                    else
                    begin
                        if (opcode_reg != tcts_pkg::OPC_ACK)
                        begin
                            push.count = 2'd1;
                            push.first = tcts_pkg::mk_result(tcts_pkg::KIND_ERROR,
                                '0, '0, 1'b0, '0, tcts_pkg::ST_UNEXPECTED, 1'b1, 1'b1);
                            mode_next  = tcts_pkg::MODE_IDLE;
                            timer_next = '0;
                            retry_next = '0;
                        end
                        else if (pblk_reg == block_reg)
                        begin
                            if (final_reg)
                            begin
                                push.count = 2'd1;
                                push.first = tcts_pkg::mk_result(tcts_pkg::KIND_NONE,
                                    '0, '0, 1'b0, '0, tcts_pkg::ST_OK, 1'b1, 1'b1);
                                mode_next  = tcts_pkg::MODE_IDLE;
                                timer_next = '0;
                                retry_next = '0;
                            end
                            else
                            begin
                                block_next = blk_inc;
                                final_next = chunk < tcts_pkg::BLOCK_LEN;
                                retry_next = '0;
                                timer_next = tcts_pkg::TIMER_W'(base);
                                push.count = 2'd1;
                                push.first = tcts_pkg::mk_result(tcts_pkg::KIND_DATA,
                                    blk_inc, chunk, 1'b0, '0, tcts_pkg::ST_OK,
                                    1'b0, 1'b1);
                            end
                        end
                    end
                end
            end
            default: ;
        endcase

        if (!fire)
            push.count = 2'd0;
    end

endmodule
`default_nettype wire

[src/tcts_result_fifo.sv]
`default_nettype none
module tcts_result_fifo (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire tcts_pkg::result_push_t push,
    output logic                        room,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output tcts_pkg::result_t           head
);

    localparam int unsigned DEPTH = 4;
    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = PTR_W + 1;

    tcts_pkg::result_t  mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               pop;
    logic [PTR_W-1:0]   wr_ptr_inc;

    assign out_valid  = (count_reg != '0);
    assign pop        = out_valid && !out_stall;
    assign head       = mem[rd_ptr_reg];
    // two free slots are needed for the worst-case request
    assign room       = (count_reg <= CNT_W'(DEPTH - 2));
    assign wr_ptr_inc = wr_ptr_reg + PTR_W'(1);
    assign count_next = count_reg + CNT_W'(push.count) - CNT_W'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + PTR_W'(push.count);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
            mem[wr_ptr_reg] <= push.first;
        if (push.count == 2'd2)
            mem[wr_ptr_inc] <= push.second;
    end

endmodule
`default_nettype wire

[tb/sv/tftp_client_transfer_sequencer_core_tb.sv]
`timescale 1ns / 1ps
`default_nettype none
module tftp_client_transfer_sequencer_core_tb;
    import tcts_pkg::*;

    typedef struct packed {
        logic [1:0]         act;
        logic [LEN_W-1:0]   length;
        logic [15:0]        opcode;
        logic [BLOCK_W-1:0] blk;
        logic [LEN_W-1:0]   chunk;
        logic               stored;
    } request_t;

    logic                 clk;
    logic                 rst_n = 1'b0;
    logic                 write_enable = 1'b0;
    logic                 write_index = 1'b0;
    logic [TICKS_W-1:0]   write_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [1:0]           action = '0;
    logic [LEN_W-1:0]     packet_length = '0;
    logic [15:0]          packet_opcode = '0;
    logic [BLOCK_W-1:0]   packet_block = '0;
    logic [LEN_W-1:0]     next_chunk_length = '0;
    logic                 store_succeeded = 1'b0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [2:0]           send_kind;
    logic [BLOCK_W-1:0]   send_block;
    logic [LEN_W-1:0]     send_length;
    logic                 store_payload;
    logic [LEN_W-1:0]     payload_length;
    logic [2:0]           status;
    logic                 session_done;
    logic                 last_result;

    // shadow configuration and session state
    logic [TICKS_W-1:0]   cfg_timeout = TIMEOUT_RESET;
    logic [RETRY_W-1:0]   cfg_limit = RETRY_RESET;
    mode_t                sess_mode = MODE_IDLE;
    logic [BLOCK_W-1:0]   sess_block = '0;
    logic                 sess_final = 1'b0;
    logic [RETRY_W-1:0]   sess_retries = '0;
    logic [TIMER_W-1:0]   sess_timer = '0;

    result_t              due_results[$];
    int unsigned          active_items = 0;
    int unsigned          mismatches = 0;
    int unsigned          send_calm = 0;
    int unsigned          take_calm = 0;
    bit                   peer_quiet = 1'b0;

    tftp_client_transfer_sequencer_core uut (
        .clk               (clk),
        .rst_n             (rst_n),
        .write_enable      (write_enable),
        .write_index       (write_index),
        .write_data        (write_data),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .action            (action),
        .packet_length     (packet_length),
        .packet_opcode     (packet_opcode),
        .packet_block      (packet_block),
        .next_chunk_length (next_chunk_length),
        .store_succeeded   (store_succeeded),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .send_kind         (send_kind),
        .send_block        (send_block),
        .send_length       (send_length),
        .store_payload     (store_payload),
        .payload_length    (payload_length),
        .status            (status),
        .session_done      (session_done),
        .last_result       (last_result)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #8_000_000;
        $display("FAIL tftp_client_transfer_sequencer_core");
        $finish;
    end

    // idle cycles for one request, with occasional stretches of none
    function automatic int unsigned draw_wait(inout int unsigned calm);
        if (calm != 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 39) == 0)
        begin
            calm = $urandom_range(20, 60);
            return 0;
        end
        return ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 13);
    endfunction

    task automatic flag_mismatch(input string what);
        mismatches++;
        $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            flag_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    task automatic post_result(input logic [2:0] kind, input logic [BLOCK_W-1:0] blk,
                               input logic [LEN_W-1:0] slen, input logic store,
                               input logic [LEN_W-1:0] plen, input logic [2:0] st,
                               input logic done, input logic last);
        result_t r;
        r.send_kind      = kind;
        r.send_block     = blk;
        r.send_length    = slen;
        r.store_payload  = store;
        r.payload_length = plen;
        r.status         = st;
        r.session_done   = done;
        r.last_result    = last;
        due_results.push_back(r);
    endtask

    function automatic logic [TIMER_W-1:0] base_ticks();
        return (cfg_timeout == '0) ? TIMER_W'(1) : TIMER_W'(cfg_timeout);
    endfunction

    task automatic arm_timer();
        sess_retries = '0;
        sess_timer   = base_ticks();
    endtask

    task automatic close_session();
        sess_mode    = MODE_IDLE;
        sess_timer   = '0;
        sess_retries = '0;
    endtask

    task automatic abort_session(input logic [2:0] st);
        post_result(KIND_ERROR, '0, '0, 1'b0, '0, st, 1'b1, 1'b1);
        close_session();
    endtask

    // advance the shadow session by one accepted request
    task automatic advance_session(input request_t r);
        logic [LEN_W-1:0] pay;
        logic [LEN_W-1:0] chunk;
        logic             ends;
        active_items++;
        if (r.act == ACT_START_READ || r.act == ACT_START_WRITE)
        begin
            if (sess_mode != MODE_IDLE)
            begin
                active_items--;
                return;
            end
            sess_mode  = (r.act == ACT_START_READ) ? MODE_READ : MODE_WRITE;
            sess_block = '0;
            sess_final = 1'b0;
            arm_timer();
            post_result((r.act == ACT_START_READ) ? KIND_RRQ : KIND_WRQ, '0, '0, 1'b0, '0,
                        ST_OK, 1'b0, 1'b1);
            return;
        end
        if (sess_mode == MODE_IDLE)
        begin
            active_items--;
            return;
        end
        if (r.act == ACT_TICK)
        begin
            if (sess_timer == '0)
            begin
                active_items--;
                return;
            end
            sess_timer = sess_timer - 1'b1;
            if (sess_timer != '0)
                return;
            if (sess_retries > cfg_limit || sess_retries == RETRY_MAX)
            begin
                post_result(KIND_RETX, sess_block, '0, 1'b0, '0, ST_OK, 1'b0, 1'b0);
                abort_session(ST_RETRY_TMO);
                return;
            end
            sess_retries = sess_retries + 1'b1;
            sess_timer   = base_ticks() << sess_retries;
            post_result(KIND_RETX, sess_block, '0, 1'b0, '0, ST_OK, 1'b0, 1'b1);
            return;
        end
        if (r.length < HDR_LEN || r.length > MAX_PKT)
        begin
            abort_session(ST_WRONG_SIZE);
            return;
        end
        if (r.opcode == OPC_ERROR)
        begin
            post_result(KIND_NONE, '0, '0, 1'b0, '0, ST_PEER_ERR, 1'b0, 1'b1);
            return;
        end
        if (sess_mode == MODE_READ)
        begin
            if (r.opcode != OPC_DATA)
            begin
                abort_session(ST_UNEXPECTED);
                return;
            end
            if (r.blk != sess_block + 16'd1)
            begin
                active_items--;
                return;
            end
            pay = r.length - HDR_LEN;
            if (pay != '0 && !r.stored)
            begin
                abort_session(ST_STORE_ERR);
                return;
            end
            sess_block = r.blk;
            arm_timer();
            ends = (pay < BLOCK_LEN);
            post_result(KIND_ACK, sess_block, '0, pay != '0, pay, ST_OK, ends, 1'b1);
            if (ends)
                close_session();
            return;
        end
        if (r.opcode != OPC_ACK)
        begin
            abort_session(ST_UNEXPECTED);
            return;
        end
        if (r.blk != sess_block)
        begin
            active_items--;
            return;
        end
        if (sess_final)
        begin
            post_result(KIND_NONE, '0, '0, 1'b0, '0, ST_OK, 1'b1, 1'b1);
            close_session();
            return;
        end
        chunk      = (r.chunk > BLOCK_LEN) ? BLOCK_LEN : r.chunk;
        sess_block = sess_block + 16'd1;
        sess_final = (chunk < BLOCK_LEN);
        arm_timer();
        post_result(KIND_DATA, sess_block, chunk, 1'b0, '0, ST_OK, 1'b0, 1'b1);
    endtask

    function automatic request_t scatter();
        request_t r;
        r.act    = 2'($urandom_range(0, 3));
        r.length = LEN_W'($urandom_range(0, 1023));
        r.opcode = 16'($urandom);
        r.blk    = 16'($urandom);
        r.chunk  = LEN_W'($urandom_range(0, 1023));
        r.stored = 1'($urandom_range(0, 1));
        return r;
    endfunction

    function automatic request_t compose(input logic [1:0] act, input logic [LEN_W-1:0] length,
                                         input logic [15:0] opcode, input logic [15:0] blk,
                                         input logic [LEN_W-1:0] chunk, input logic stored);
        request_t r;
        r.act    = act;
        r.length = length;
        r.opcode = opcode;
        r.blk    = blk;
        r.chunk  = chunk;
        r.stored = stored;
        return r;
    endfunction

    // mostly well-formed traffic for the current session, some faults and noise
    function automatic request_t pick_request();
        request_t    r;
        int unsigned roll;
        int unsigned size_roll;
        r    = scatter();
        roll = $urandom_range(0, 99);
        if (sess_mode == MODE_IDLE)
        begin
            if (roll < 90)
                r.act = ($urandom_range(0, 1) == 0) ? ACT_START_READ : ACT_START_WRITE;
            return r;
        end
        if (peer_quiet && roll < 95)
        begin
            r.act = ACT_TICK;
            return r;
        end
        if (roll < 68)
        begin
            r.act = ACT_PACKET;
            if (sess_mode == MODE_READ)
            begin
                r.opcode  = OPC_DATA;
                r.blk     = sess_block + 16'd1;
                size_roll = $urandom_range(0, 99);
                if (size_roll < 58)
                    r.length = MAX_PKT;
                else if (size_roll < 94)
                    r.length = LEN_W'($urandom_range(4, 515));
                else
                    r.length = HDR_LEN;
                r.stored = ($urandom_range(0, 24) != 0);
            end
            else
            begin
                r.opcode = OPC_ACK;
                r.blk    = sess_block;
                r.length = ($urandom_range(0, 3) != 0) ? HDR_LEN
                                                      : LEN_W'($urandom_range(4, 516));
                r.chunk  = ($urandom_range(0, 2) != 0) ? LEN_W'($urandom_range(512, 1023))
                                                      : LEN_W'($urandom_range(0, 511));
            end
        end
        else if (roll < 80)
            r.act = ACT_TICK;
        else if (roll < 85)
        begin
            r.act    = ACT_PACKET;
            r.opcode = OPC_ERROR;
            r.length = LEN_W'($urandom_range(4, 516));
        end
        else if (roll < 92)
        begin
            // likely a stale or future block number
            r.act    = ACT_PACKET;
            r.opcode = (sess_mode == MODE_READ) ? OPC_DATA : OPC_ACK;
            r.length = LEN_W'($urandom_range(4, 516));
        end
        else if (roll < 95)
            r.act = ($urandom_range(0, 1) == 0) ? ACT_START_READ : ACT_START_WRITE;
        return r;
    endfunction

    // called at a rising edge; returns at the edge that accepts the request
    task automatic send_request(input request_t r);
        int unsigned gap;
        gap = draw_wait(send_calm);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid          <= 1'b1;
        action            <= r.act;
        packet_length     <= r.length;
        packet_opcode     <= r.opcode;
        packet_block      <= r.blk;
        next_chunk_length <= r.chunk;
        store_succeeded   <= r.stored;
        @(posedge clk);
        while (in_stall !== 1'b0)
            @(posedge clk);
        advance_session(r);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (due_results.size() != 0)
            @(posedge clk);
        // let requests that produce nothing drain out of the pipeline
        repeat (8) @(posedge clk);
    endtask

    task automatic write_config(input logic [TICKS_W-1:0] ticks, input logic [RETRY_W-1:0] limit);
        write_enable <= 1'b1;
        write_index  <= CFG_TIMEOUT_TICKS;
        write_data   <= ticks;
        @(posedge clk);
        write_index  <= CFG_RETRY_LIMIT;
        write_data   <= TICKS_W'(limit);
        @(posedge clk);
        write_enable <= 1'b0;
        cfg_timeout = ticks;
        cfg_limit   = limit;
    endtask

    task automatic test_reset_settings_read();
        send_request(compose(ACT_TICK, 10'd0, 16'd0, 16'd0, 10'd0, 1'b0));
        send_request(compose(ACT_PACKET, MAX_PKT, OPC_DATA, 16'd1, 10'd0, 1'b1));
        send_request(compose(ACT_START_READ, 10'd0, 16'd0, 16'd0, 10'd0, 1'b0));
        send_request(compose(ACT_TICK, 10'd0, 16'd0, 16'd0, 10'd0, 1'b0));
        send_request(compose(ACT_PACKET, MAX_PKT, OPC_DATA, 16'd1, 10'd0, 1'b1));
        send_request(compose(ACT_PACKET, MAX_PKT, OPC_DATA, 16'd5, 10'd0, 1'b1));
        // empty final block, store flag low
        send_request(compose(ACT_PACKET, HDR_LEN, OPC_DATA, 16'd2, 10'd0, 1'b0));
        settle();
    endtask

    task automatic test_write_transfer();
        send_request(compose(ACT_START_WRITE, 10'd0, 16'd0, 16'd0, 10'd0, 1'b0));
        send_request(compose(ACT_START_READ, 10'd0, 16'd0, 16'd0, 10'd0, 1'b0));
        send_request(compose(ACT_PACKET, HDR_LEN, OPC_ACK, 16'd7, 10'd100, 1'b0));
        send_request(compose(ACT_PACKET, HDR_LEN, OPC_ACK, 16'd0, 10'd1023, 1'b0));
        send_request(compose(ACT_PACKET, HDR_LEN, OPC_ERROR, 16'hFFFF, 10'd0, 1'b1));
        send_request(compose(ACT_PACKET, HDR_LEN, OPC_ACK, 16'd1, 10'd0, 1'b0));
        send_request(compose(ACT_PACKET, HDR_LEN, OPC_ACK, 16'd2, 10'd0, 1'b0));
        settle();
    endtask

    task automatic test_packet_faults();
        send_request(compose(ACT_START_READ, 10'd0, 16'd0, 16'd0, 10'd0, 1'b0));
        send_request(compose(ACT_PACKET, 10'd3, OPC_DATA, 16'd1, 10'd0, 1'b1));
        send_request(compose(ACT_START_READ, 10'd0, 16'd0, 16'd0, 10'd0, 1'b0));
        send_request(compose(ACT_PACKET, 10'd1023, OPC_DATA, 16'd1, 10'd0, 1'b1));
        send_request(compose(ACT_START_WRITE, 10'd0, 16'd0, 16'd0, 10'd0, 1'b0));
        send_request(compose(ACT_PACKET, HDR_LEN, 16'hFFFF, 16'd0, 10'd512, 1'b1));
        send_request(compose(ACT_START_READ, 10'd0, 16'd0, 16'd0, 10'd0, 1'b0));
        send_request(compose(ACT_PACKET, 10'd300, OPC_DATA, 16'd1, 10'd0, 1'b0));
        settle();
    endtask

    task automatic test_retry_abort();
        // zero timeout behaves as one tick; a retry limit of zero still allows one retry
        write_config(16'd0, 3'd0);
        send_request(compose(ACT_START_WRITE, 10'd0, 16'd0, 16'd0, 10'd0, 1'b0));
        repeat (3) send_request(compose(ACT_TICK, 10'd0, 16'd0, 16'd0, 10'd0, 1'b0));
        settle();
    endtask

    task automatic test_random_sessions(input logic [TICKS_W-1:0] ticks,
                                        input logic [RETRY_W-1:0] limit,
                                        input int unsigned quota);
        int unsigned target;
        bit          was_idle;
        write_config(ticks, limit);
        target = active_items + quota;
        while (active_items < target)
        begin
            was_idle = (sess_mode == MODE_IDLE);
            send_request(pick_request());
            // some sessions see a silent peer and run into the retry limit
            if (was_idle && sess_mode != MODE_IDLE)
                peer_quiet = (base_ticks() <= 2) && ($urandom_range(0, 7) == 0);
        end
        settle();
    endtask

    initial
    begin : result_monitor
        int unsigned hold;
        result_t     want;
        forever
        begin
            hold = draw_wait(take_calm);
            if (hold != 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (out_valid !== 1'b1)
                @(posedge clk);
            if (due_results.size() == 0)
                flag_mismatch($sformatf("unexpected result kind %0d status %0d",
                                        send_kind, status));
            else
            begin
                want = due_results.pop_front();
                check_field("send_kind", 16'(send_kind), 16'(want.send_kind));
                check_field("send_block", send_block, want.send_block);
                check_field("send_length", 16'(send_length), 16'(want.send_length));
                check_field("store_payload", 16'(store_payload),
                            16'(want.store_payload));
                check_field("payload_length", 16'(payload_length),
                            16'(want.payload_length));
                check_field("status", 16'(status), 16'(want.status));
                check_field("session_done", 16'(session_done), 16'(want.session_done));
                check_field("last_result", 16'(last_result), 16'(want.last_result));
            end
        end
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_settings_read();
        test_write_transfer();
        test_packet_faults();
        test_retry_abort();
        test_random_sessions(16'd1, 3'd7, 350);
        test_random_sessions(16'd65535, 3'd0, 200);
        test_random_sessions(16'd2, 3'd2, 300);
        test_random_sessions(16'd0, 3'd5, 300);
        test_random_sessions(TIMEOUT_RESET, RETRY_RESET, 150);
        test_random_sessions(16'd3, 3'd6, 300);
        test_random_sessions(16'd1, 3'd1, 200);
        if (mismatches == 0)
            $display("PASS tftp_client_transfer_sequencer_core");
        else
            $display("FAIL tftp_client_transfer_sequencer_core");
        $finish;
    end

endmodule
`default_nettype wire
